// ----- sv/crsf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_pkg: shared constants, types and CRC function
// Frame format constants, payload types and the CRC-8 (poly 0xD5) byte step
// for the RC channels frame parser.
// ----------------------------------------------------------------------------
package crsf_pkg;

    localparam int BUFFER_BYTES_DEF = 64;

    localparam int BYTE_W     = 8;
    localparam int RC_PAYLOAD = 22;
    localparam int CHANNELS   = 16;
    localparam int CH_BITS    = 11;
    localparam int CH_IDX_W   = 4;
    localparam int PIDX_W     = 5;        // index into the 22-byte payload store
    localparam int PAYLOAD_W  = RC_PAYLOAD * BYTE_W;

    localparam logic [7:0] RC_TYPE      = 8'h16;
    localparam logic [7:0] RC_LENGTH    = 8'd24;
    localparam logic [7:0] MIN_LENGTH   = 8'd2;
    localparam logic [7:0] CRC_POLY     = 8'hD5;
    localparam logic [7:0] SYNC_RESET   = 8'd200;

    // frame positions: 1 length, 2 type, 3.. payload
    localparam int POS_LENGTH  = 1;
    localparam int POS_TYPE    = 2;
    localparam int POS_PAYLOAD = 3;

    typedef logic [PAYLOAD_W-1:0] payload_t;

    // parser -> emitter
    typedef struct packed {
        logic     ok;
        payload_t payload;
    } frame_t;

    // emitter -> parser
    typedef struct packed {
        logic busy;
    } emit_stat_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ----- sv/crsf_byte_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_byte_if: received byte channel
// Valid/ready channel carrying one link byte per transaction.
// ----------------------------------------------------------------------------
interface crsf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- sv/crsf_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_chan_if: decoded channel channel
// Valid/ready channel carrying one RC channel value per transaction.
// ----------------------------------------------------------------------------
interface crsf_chan_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel_index;
    logic [10:0] channel_value;
    logic        last_channel;

    modport source (output valid, output channel_index, output channel_value,
                    output last_channel, input ready);
    modport sink   (input valid, input channel_index, input channel_value,
                    input last_channel, output ready);
endinterface

// ----- sv/crsf_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_cfg_if: configuration write channel
// Valid/ready channel carrying the sync address register write data.
// ----------------------------------------------------------------------------
interface crsf_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] sync_address;

    modport source (output valid, output sync_address, input ready);
    modport sink   (input valid, input sync_address, output ready);
endinterface

// ----- sv/crsf_parse.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_parse: byte-serial frame parser
// Tracks frame position, length, type and running CRC, stores the payload
// and flags a good RC channels frame on its CRC byte.
// ----------------------------------------------------------------------------
module crsf_parse #(
    parameter int BUFFER_BYTES = crsf_pkg::BUFFER_BYTES_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    crsf_byte_if.sink            rx,
    crsf_cfg_if.sink             cfg,
    input  crsf_pkg::emit_stat_t stat,
    output crsf_pkg::frame_t     frm
);

    localparam int         POS_W   = $clog2(BUFFER_BYTES + 1);
    localparam logic [7:0] MAX_LEN = 8'(BUFFER_BYTES - 2);

    logic [7:0]       sync_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       crc_reg, crc_next;
    logic [7:0]       type_reg, type_next;
    logic [7:0]       pay_reg [crsf_pkg::RC_PAYLOAD];

    logic                      accept;
    logic                      at_complete;
    logic                      pay_we;
    logic [crsf_pkg::PIDX_W-1:0] pay_idx;
    logic [POS_W-1:0]          pay_off;
    logic [7:0]                b;
    logic [8:0]                pos_w;
    logic                      frame_ok;

    assign b      = rx.rx_byte;
    assign accept = rx.valid && rx.ready;
    assign pos_w  = 9'(pos_reg);

    // CRC byte position depends on state only, so ready can look ahead
    assign at_complete = (pos_reg != '0) && (pos_w < 9'(BUFFER_BYTES))
                      && (pos_w != 9'(crsf_pkg::POS_LENGTH))
                      && (pos_w == {1'b0, len_reg} + 9'd1);

    assign rx.ready  = !(at_complete && stat.busy);
    assign cfg.ready = 1'b1;

    assign pay_off = pos_reg - POS_W'(crsf_pkg::POS_PAYLOAD);
    assign pay_idx = pay_off[crsf_pkg::PIDX_W-1:0];

    always_comb
    begin
        pos_next  = pos_reg;
        len_next  = len_reg;
        crc_next  = crc_reg;
        type_next = type_reg;
        pay_we    = 1'b0;
        frame_ok  = 1'b0;
        if (accept)
        begin
            if (pos_reg == '0)
            begin
                if (b == sync_reg)
                begin
                    pos_next = POS_W'(1);
                    crc_next = 8'd0;
                end
            end
            else if (pos_w >= 9'(BUFFER_BYTES))
            begin
                pos_next = '0;
                len_next = 8'd0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
                if (pos_w == 9'(crsf_pkg::POS_LENGTH))
                begin
                    len_next = b;
                    if (b < crsf_pkg::MIN_LENGTH || b > MAX_LEN)
                    begin
                        pos_next = '0;
                        len_next = 8'd0;
                    end
                end
                else
                begin
                    if (pos_w == 9'(crsf_pkg::POS_TYPE))
                    begin
                        type_next = b;
                        crc_next  = crsf_pkg::crc8_step(crc_reg, b);
                    end
                    else if (pos_w <= {1'b0, len_reg})
                    begin
                        crc_next = crsf_pkg::crc8_step(crc_reg, b);
                        pay_we   = (pos_w >= 9'(crsf_pkg::POS_PAYLOAD))
                                && (pos_w < 9'(crsf_pkg::POS_PAYLOAD + crsf_pkg::RC_PAYLOAD));
                    end
                    if (at_complete)
                    begin
                        // b is the received CRC
                        frame_ok = (type_reg == crsf_pkg::RC_TYPE)
                                && (len_reg == crsf_pkg::RC_LENGTH)
                                && (crc_reg == b);
                        pos_next = '0;
                        len_next = 8'd0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg <= crsf_pkg::SYNC_RESET;
            pos_reg  <= '0;
            len_reg  <= 8'd0;
            crc_reg  <= 8'd0;
            type_reg <= 8'd0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                sync_reg <= cfg.sync_address;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
            crc_reg  <= crc_next;
            type_reg <= type_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pay_we)
            pay_reg[pay_idx] <= b;
    end

    always_comb
    begin
        frm.ok = frame_ok;
        for (int i = 0; i < crsf_pkg::RC_PAYLOAD; i++)
            frm.payload[i*crsf_pkg::BYTE_W +: crsf_pkg::BYTE_W] = pay_reg[i];
    end

endmodule

// ----- sv/crsf_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_emit: channel unpacker and output register
// Holds a copy of a good frame's payload and sends its sixteen 11-bit
// channels, LSB first, through a registered output stage.
// ----------------------------------------------------------------------------
module crsf_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crsf_pkg::frame_t     frm,
    output crsf_pkg::emit_stat_t stat,
    crsf_chan_if.source          chan
);

    crsf_pkg::payload_t             shadow_reg;
    logic [crsf_pkg::CH_IDX_W-1:0]  cnt_reg;
    logic                           pend_reg;
    logic                           ov_reg;
    logic [crsf_pkg::CH_IDX_W-1:0]  out_idx_reg;
    logic [crsf_pkg::CH_BITS-1:0]   out_val_reg;
    logic                           out_last_reg;

    logic       load_out;
    logic       cnt_last;
    logic [7:0] ch_base;

    assign load_out = pend_reg && (!ov_reg || chan.ready);
    assign cnt_last = (cnt_reg == crsf_pkg::CH_IDX_W'(crsf_pkg::CHANNELS - 1));
    assign ch_base  = 8'(cnt_reg) * 8'(crsf_pkg::CH_BITS);

    assign stat.busy = pend_reg || ov_reg;

    assign chan.valid         = ov_reg;
    assign chan.channel_index = out_idx_reg;
    assign chan.channel_value = out_val_reg;
    assign chan.last_channel  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (frm.ok)
            begin
                pend_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (load_out)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_last)
                    pend_reg <= 1'b0;
            end

            if (load_out)
                ov_reg <= 1'b1;
            else if (chan.ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frm.ok)
            shadow_reg <= frm.payload;
        if (load_out)
        begin
            out_idx_reg  <= cnt_reg;
            out_val_reg  <= shadow_reg[ch_base +: crsf_pkg::CH_BITS];
            out_last_reg <= cnt_last;
        end
    end

`ifndef NO_ASSERTIONS
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        frm.ok |-> !pend_reg && !ov_reg)
        else $error("frame loaded while channels still pending");

    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        frm.ok |=> pend_reg && (cnt_reg == '0))
        else $error("emission did not start at channel zero");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_last_reg |->
            out_idx_reg == crsf_pkg::CH_IDX_W'(crsf_pkg::CHANNELS - 1))
        else $error("last mark on wrong channel");

    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        load_out && cnt_last && !frm.ok |=> !pend_reg)
        else $error("emission continued past last channel");
`endif

endmodule

// ----- sv/crsf_rc_frame_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crsf_rc_frame_parser: CRSF RC channels packed frame parser
// Parses a byte stream, checks type, length and CRC-8 of each frame and
// emits the sixteen 11-bit channels of every good RC channels frame.
// ----------------------------------------------------------------------------
//  port   dir  transaction
//  rx     in   one received link byte (rx_byte)
//  chan   out  one channel: channel_index, channel_value, last_channel
//  cfg    in   write of sync_address, always ready
//
//  One byte per cycle. A good frame gives 16 channels, one per cycle while chan is ready, from
//  a payload copy, overlapping the next frame's bytes.
//  rx stalls only on a CRC byte while the previous frame's channels are
//  still going out. Reset: hunting for sync, sync_address = 200.
// ----------------------------------------------------------------------------
module crsf_rc_frame_parser #(
    parameter int BUFFER_BYTES = crsf_pkg::BUFFER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    crsf_byte_if.sink   rx,
    crsf_chan_if.source chan,
    crsf_cfg_if.sink    cfg
);

    crsf_pkg::frame_t     frm;
    crsf_pkg::emit_stat_t stat;

    crsf_parse #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .cfg   (cfg),
        .stat  (stat),
        .frm   (frm)
    );

    crsf_emit u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .frm   (frm),
        .stat  (stat),
        .chan  (chan)
    );

endmodule
